### sv/per_line_pattern_occurrence_counter_core_macros.svh
// Assertion macros for the per-line pattern occurrence counter
`ifndef PER_LINE_PATTERN_OCCURRENCE_COUNTER_CORE_MACROS_SVH
`define PER_LINE_PATTERN_OCCURRENCE_COUNTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define PLPOC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PLPOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PLPOC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PLPOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/plpoc_pkg.sv
package plpoc_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int LEN_W = 5;
	localparam int ADDR_W = 5;
	localparam int CFG_DATA_W = 64;
	localparam int PAT_W = 128;
	localparam int LINE_W = 32;
	localparam int CNT_W = 16;
	localparam int TOT_W = 32;
	localparam int OUT_DATA_W = 88;

	localparam logic [1:0] REG_PATTERN_LOW = 2'd0;
	localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam logic OP_TEXT = 1'b0;
	localparam logic OP_EOL = 1'b1;

	typedef struct packed {
		logic adv;
		logic eol;
		logic [7:0] text_byte;
	} item_t;

	typedef struct packed {
		logic adv;
		logic eol;
		logic hit;
	} step_t;

	typedef struct packed {
		logic [TOT_W-1:0] total_count;
		logic found;
		logic [CNT_W-1:0] line_count;
		logic [LINE_W-1:0] line_number;
	} result_t;

endpackage

### sv/plpoc_cfg_regs.sv
module plpoc_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [plpoc_pkg::ADDR_W-1:0] paddr,
	input  logic [plpoc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [plpoc_pkg::CFG_DATA_W-1:0] prdata,
	output logic pready,
	output logic [plpoc_pkg::PAT_W-1:0] pattern,
	output logic [plpoc_pkg::LEN_W-1:0] pattern_length
);

	logic [63:0] low_q;
	logic [63:0] high_q;
	logic [plpoc_pkg::LEN_W-1:0] len_q;
	logic [1:0] reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			high_q <= '0;
			len_q <= plpoc_pkg::LEN_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				plpoc_pkg::REG_PATTERN_LOW: low_q <= pwdata;
				plpoc_pkg::REG_PATTERN_HIGH: high_q <= pwdata;
				plpoc_pkg::REG_PATTERN_LENGTH: len_q <= pwdata[plpoc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			plpoc_pkg::REG_PATTERN_LOW: prdata = low_q;
			plpoc_pkg::REG_PATTERN_HIGH: prdata = high_q;
			plpoc_pkg::REG_PATTERN_LENGTH:
				prdata = {{(plpoc_pkg::CFG_DATA_W-plpoc_pkg::LEN_W){1'b0}}, len_q};
			default: prdata = '0;
		endcase
	end

	assign pattern = {high_q, low_q};
	assign pattern_length = len_q;

endmodule

### sv/plpoc_window.sv
module plpoc_window #(
	parameter int MAX_PATTERN_BYTES = plpoc_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  plpoc_pkg::item_t item,
	input  logic [plpoc_pkg::PAT_W-1:0] pattern,
	input  logic [plpoc_pkg::LEN_W-1:0] pattern_length,
	output logic hit
);

	localparam int BW = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int LW = plpoc_pkg::LEN_W;

	logic [7:0] win_q [MAX_PATTERN_BYTES];
	logic [7:0] win_next [MAX_PATTERN_BYTES];
	logic [BW-1:0] bytes_q;
	logic [BW-1:0] bytes_next;
	logic [LW-1:0] len;

	always_comb begin
		win_next[0] = item.text_byte;
		for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
			win_next[j] = win_q[j-1];
		end
		bytes_next = (bytes_q == BW'(MAX_PATTERN_BYTES)) ? bytes_q : bytes_q + BW'(1);
		if (pattern_length == '0) begin
			len = LW'(1);
		end else if (pattern_length > LW'(MAX_PATTERN_BYTES)) begin
			len = LW'(MAX_PATTERN_BYTES);
		end else begin
			len = pattern_length;
		end
	end

	always_comb begin
		logic [LW-1:0] idx;
		idx = '0;
		hit = (LW'(bytes_next) >= len);
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			if (LW'(k) < len) begin
				idx = len - LW'(1) - LW'(k);
				if (win_next[idx[IW-1:0]] != pattern[8*k +: 8]) begin
					hit = 1'b0;
				end
			end
		end
	end

	// shift on each text byte; a line end only restarts the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
				win_q[j] <= '0;
			end
			bytes_q <= '0;
		end else if (item.adv) begin
			if (item.eol) begin
				bytes_q <= '0;
			end else begin
				win_q <= win_next;
				bytes_q <= bytes_next;
			end
		end
	end

endmodule

### sv/plpoc_counters.sv
module plpoc_counters (
	input  logic clk,
	input  logic arst_n,
	input  plpoc_pkg::step_t step,
	input  logic out_ready,
	output logic out_valid,
	output plpoc_pkg::result_t result
);

	logic [plpoc_pkg::LINE_W-1:0] line_q;
	logic [plpoc_pkg::CNT_W-1:0] mil_q;
	logic [plpoc_pkg::TOT_W-1:0] tot_q;
	logic out_valid_q;
	plpoc_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= plpoc_pkg::LINE_W'(1);
			mil_q <= '0;
			tot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step.adv) begin
				if (step.eol) begin
					out_valid_q <= 1'b1;
					mil_q <= '0;
					if (line_q != '1) begin
						line_q <= line_q + plpoc_pkg::LINE_W'(1);
					end
				end else if (step.hit) begin
					if (mil_q != '1) begin
						mil_q <= mil_q + plpoc_pkg::CNT_W'(1);
					end
					if (tot_q != '1) begin
						tot_q <= tot_q + plpoc_pkg::TOT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.adv && step.eol) begin
			result_q.line_number <= line_q;
			result_q.line_count <= mil_q;
			result_q.found <= (mil_q != '0);
			result_q.total_count <= tot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result = result_q;

endmodule

### sv/per_line_pattern_occurrence_counter_core.sv
// A line end accepted at the input passes through the input register and then the result
// register before its result is on m_tdata; it can be held in the input register between.
// Throughput: one transfer per cycle while no line end is held; a text byte never waits on the output side.
// A line end waits in the input register only while the result register is still held.
// Reset (arst_n low, asynchronous): window and counters cleared, line number set to one,
// pattern registers zero and pattern length one.
`include "per_line_pattern_occurrence_counter_core_macros.svh"

module per_line_pattern_occurrence_counter_core #(
	parameter int MAX_PATTERN_BYTES = plpoc_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,  // text_byte [7:0]
	input  logic s_tuser,        // op [0]
	output logic m_tvalid,
	input  logic m_tready,
	// line_number [31:0], line_count [47:32], found [48], total_count [80:49], zero [87:81]
	output logic [plpoc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [plpoc_pkg::ADDR_W-1:0] paddr,
	input  logic [plpoc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [plpoc_pkg::CFG_DATA_W-1:0] prdata,
	output logic pready
);

	logic valid_s1;
	logic op_s1;
	logic [7:0] byte_s1;
	logic adv_s1;
	logic hit;
	logic [plpoc_pkg::PAT_W-1:0] pattern;
	logic [plpoc_pkg::LEN_W-1:0] pattern_length;
	plpoc_pkg::item_t item;
	plpoc_pkg::step_t step;
	plpoc_pkg::result_t result;

	plpoc_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.pattern        (pattern),
		.pattern_length (pattern_length)
	);

	// hold a line end while the result register is occupied and not being taken
	assign adv_s1 = valid_s1 && (op_s1 == plpoc_pkg::OP_TEXT || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign item.adv = adv_s1;
	assign item.eol = (op_s1 == plpoc_pkg::OP_EOL);
	assign item.text_byte = byte_s1;

	plpoc_window #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.pattern        (pattern),
		.pattern_length (pattern_length),
		.hit            (hit)
	);

	assign step.adv = adv_s1;
	assign step.eol = item.eol;
	assign step.hit = hit;

	plpoc_counters u_counters (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.result    (result)
	);

	assign m_tdata = {{(plpoc_pkg::OUT_DATA_W - $bits(result)){1'b0}}, result};

	`PLPOC_ASSERT_IMPL(a_eol_stall, clk, arst_n,
		valid_s1 && op_s1 == plpoc_pkg::OP_EOL && m_tvalid && !m_tready, !s_tready)
	`PLPOC_ASSERT_NEXT(a_eol_result, clk, arst_n, step.adv && step.eol, m_tvalid)
	`PLPOC_ASSERT_IMPL(a_found, clk, arst_n, m_tvalid, result.found == (result.line_count != '0))
	`PLPOC_ASSERT_IMPL(a_total_ge_line, clk, arst_n, m_tvalid,
		result.total_count >= plpoc_pkg::TOT_W'(result.line_count))

endmodule
